// ----- rtl/hrlp_pkg.sv -----
// Package for the HTTP request line parser.
// Holds the phase type, character codes, tag codes, the result struct and digit fold.
// No dependencies.
package hrlp_pkg;

    localparam logic [7:0] CH_SP   = 8'd32;
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_DOT  = 8'd46;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [3:0] DEC_BASE = 4'd10;
    localparam logic [7:0] ACC_MAX = 8'd255;

    localparam logic [1:0] TAG_NONE   = 2'd0;
    localparam logic [1:0] TAG_METHOD = 2'd1;
    localparam logic [1:0] TAG_URI    = 2'd2;

    localparam logic ST_PARSING = 1'b0;
    localparam logic ST_DONE    = 1'b1;

    typedef enum logic [16:0] {
        PH_M_FIRST      = 17'h00001,
        PH_M            = 17'h00002,
        PH_URI          = 17'h00004,
        PH_SKIP1        = 17'h00008,
        PH_SKIP2        = 17'h00010,
        PH_SKIP3        = 17'h00020,
        PH_SKIP4        = 17'h00040,
        PH_SKIP5        = 17'h00080,
        PH_MAJ_FIRST    = 17'h00100,
        PH_MAJ          = 17'h00200,
        PH_MIN_FIRST    = 17'h00400,
        PH_MIN          = 17'h00800,
        PH_LF_AFTER_VER = 17'h01000,
        PH_LINE_START   = 17'h02000,
        PH_HEADER       = 17'h04000,
        PH_LF_AFTER_HDR = 17'h08000,
        PH_DONE         = 17'h10000
    } hrlp_phase_t;

    typedef struct packed {
        logic       parse_status;
        logic [1:0] byte_tag;
        logic [7:0] out_byte;
        logic [7:0] major_version;
        logic [7:0] minor_version;
    } hrlp_result_t;

    function automatic logic [7:0] fold_digit(input logic [7:0] acc, input logic [7:0] b);
        logic [11:0] sum;
        logic [11:0] diff;
        logic [7:0]  res;
        sum  = 12'(acc) * 12'(DEC_BASE) + 12'(b);
        diff = sum - 12'(CH_ZERO);
        if (sum < 12'(CH_ZERO))
        begin
            res = 8'd0;
        end
        else if (diff > 12'(ACC_MAX))
        begin
            res = ACC_MAX;
        end
        else
        begin
            res = diff[7:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/hrlp_core.sv -----
// Parse state machine and version accumulators for the HTTP request line parser.
// Computes one result per byte and updates state on advance. Depends on hrlp_pkg.
module hrlp_core
    import hrlp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  logic [7:0]   in_byte,
    output hrlp_result_t result
);

    hrlp_phase_t phase_reg;
    hrlp_phase_t phase_next;
    logic [7:0]  major_reg;
    logic [7:0]  major_next;
    logic [7:0]  minor_reg;
    logic [7:0]  minor_next;
    logic        status;
    logic [1:0]  tag;

    always_comb
    begin
        phase_next = phase_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        status     = ST_PARSING;
        tag        = TAG_NONE;
        case (phase_reg)
            PH_M:
            begin
                if (in_byte == CH_SP)
                    phase_next = PH_URI;
                else
                    tag = TAG_METHOD;
            end
            PH_URI:
            begin
                if (in_byte == CH_SP)
                    phase_next = PH_SKIP1;
                else
                    tag = TAG_URI;
            end
            PH_SKIP1: phase_next = PH_SKIP2;
            PH_SKIP2: phase_next = PH_SKIP3;
            PH_SKIP3: phase_next = PH_SKIP4;
            PH_SKIP4: phase_next = PH_SKIP5;
            PH_SKIP5:
            begin
                major_next = 8'd0;
                minor_next = 8'd0;
                phase_next = PH_MAJ_FIRST;
            end
            PH_MAJ_FIRST:
            begin
                major_next = fold_digit(major_reg, in_byte);
                phase_next = PH_MAJ;
            end
            PH_MAJ:
            begin
                if (in_byte == CH_DOT)
                    phase_next = PH_MIN_FIRST;
                else
                    major_next = fold_digit(major_reg, in_byte);
            end
            PH_MIN_FIRST:
            begin
                minor_next = fold_digit(minor_reg, in_byte);
                phase_next = PH_MIN;
            end
            PH_MIN:
            begin
                if (in_byte == CH_CR)
                    phase_next = PH_LF_AFTER_VER;
                else
                    minor_next = fold_digit(minor_reg, in_byte);
            end
            PH_LF_AFTER_VER: phase_next = PH_LINE_START;
            PH_LINE_START:
            begin
                if (in_byte == CH_CR)
                    phase_next = PH_DONE;
                else
                    phase_next = PH_HEADER;
            end
            PH_HEADER:
            begin
                if (in_byte == CH_CR)
                    phase_next = PH_LF_AFTER_HDR;
            end
            PH_LF_AFTER_HDR: phase_next = PH_LINE_START;
            PH_DONE: status = ST_DONE;
            default:
            begin
                phase_next = PH_M;
                tag        = TAG_METHOD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_M_FIRST;
            major_reg <= 8'd0;
            minor_reg <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            major_reg <= major_next;
            minor_reg <= minor_next;
        end
    end

    assign result.parse_status  = status;
    assign result.byte_tag      = tag;
    assign result.out_byte      = in_byte;
    assign result.major_version = major_next;
    assign result.minor_version = minor_next;

endmodule

// ----- rtl/http_request_line_parser.sv -----
// HTTP request line parser: one byte in, one tagged result out per transfer.
// Path: an input byte is captured in the input register, then its result in the result register.
// Throughput: 1 byte per cycle while out_stall is low, set by the phase update in hrlp_core.
// Reset: asynchronous, active low; clears the valid flags of both stages and returns the parser
// to the first method byte with both version numbers at zero.
module http_request_line_parser
    import hrlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       parse_status,
    output logic [1:0] byte_tag,
    output logic [7:0] out_byte,
    output logic [7:0] major_version,
    output logic [7:0] minor_version
);

    logic         s1_valid_reg;
    logic         s1_valid_next;
    logic [7:0]   s1_byte_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    hrlp_result_t out_res_reg;
    hrlp_result_t step_res;
    logic         out_ready;
    logic         advance;
    logic         in_xfer;

    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_xfer   = in_valid && !in_stall;

    hrlp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_byte (s1_byte_reg),
        .result  (step_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payload unless a transfer moves it
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_byte_reg <= in_byte;
        if (advance)
            out_res_reg <= step_res;
    end

    assign out_valid     = out_valid_reg;
    assign parse_status  = out_res_reg.parse_status;
    assign byte_tag      = out_res_reg.byte_tag;
    assign out_byte      = out_res_reg.out_byte;
    assign major_version = out_res_reg.major_version;
    assign minor_version = out_res_reg.minor_version;

endmodule
